// File: design/mieu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mieu_pkg
// shared types, opcodes and status codes of the integer execute unit
// ----------------------------------------------------------------------------
package mieu_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NREGS    = 32;
  localparam int unsigned RIDX_W   = 5;

  localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;
  localparam logic [31:0] JUMP_INDEX_MASK  = 32'h03ff_ffff;
  localparam logic [31:0] ALL_ONES         = 32'hffff_ffff;
  localparam logic [15:0] IMM_MASK         = 16'hffff;

  localparam logic [1:0] ST_EXEC   = 2'd0;
  localparam logic [1:0] ST_BRANCH = 2'd1;
  localparam logic [1:0] ST_UNSUP  = 2'd2;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_COP0    = 6'd16;

  // cop0 rs forms
  localparam logic [4:0] C0_MF = 5'd0;
  localparam logic [4:0] C0_CF = 5'd2;
  localparam logic [4:0] C0_MT = 5'd4;
  localparam logic [4:0] C0_CT = 5'd6;

  // special function codes
  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MTHI  = 6'd17;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MTLO  = 6'd19;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_NOR   = 6'd39;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_pc;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        branch_taken;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_run;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/mieu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mieu_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module mieu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/mieu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mieu_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mieu_div
  import mieu_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [XLEN-1:0] dividend,
  input  wire logic [XLEN-1:0] divisor,
  output logic                 busy,
  output logic      [XLEN-1:0] quotient,
  output logic      [XLEN-1:0] remainder
);

  localparam int unsigned CW = $clog2(XLEN);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [XLEN-1:0] quo_r, quo_nxt, rem_r, rem_nxt, den_r;
  logic [XLEN:0]   rem_sh, diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[XLEN-1]};
    diff     = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[XLEN]) begin
        rem_nxt = diff[XLEN-1:0];
        quo_nxt = {quo_r[XLEN-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[XLEN-1:0];
        quo_nxt = {quo_r[XLEN-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(XLEN - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= divisor;
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: design/mieu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mieu_ctrl
// sequencer: accept, execute, optional divide, write back
// ----------------------------------------------------------------------------
module mieu_ctrl
  import mieu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_stat_t   stat,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.div_run ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/mieu_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mieu_dpath
// register files, decode, alu, multiplier, divider and output register
// ----------------------------------------------------------------------------
module mieu_dpath
  import mieu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_data,
  input  wire ctrl_cmd_t cmd,
  output dp_stat_t       stat,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  logic [31:0] ir_r, pc_r;
  logic [NREGS-1:0] gvld_r, cvld_r;
  logic a_vld_r, b_vld_r, c_vld_r;
  logic [31:0] ra_q, rb_q, rc_q;

  // result of execute
  logic [1:0]  res_st_r;
  logic        res_tk_r, res_we_r, hi_we_r, lo_we_r, c0_we_r, div_pend_r;
  logic        qneg_r, rneg_r;
  logic [31:0] res_npc_r, res_val_r, hi_val_r, lo_val_r, c0_val_r;
  logic [4:0]  res_idx_r, c0_idx_r;
  logic [31:0] hi_r, lo_r;

  logic        out_valid_r;
  out_word_t   out_r;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, c0, imm, zimm, pc4, pc8;

  logic [1:0]  st;
  logic        tk, wreq, hwe, lwe, cwe, drun, is_div, dsgn;
  logic [31:0] npc, wv, hv, lv, tgt, ac;
  logic [4:0]  wi;
  logic        is_br, sup;
  logic signed [65:0] prod;
  logic [31:0] nm, dm, dq, dr, fq, fr;

  logic        gwe;
  logic [31:0] gwd;

  assign op   = ir_r[31:26];
  assign rs   = ir_r[25:21];
  assign rt   = ir_r[20:16];
  assign rd   = ir_r[15:11];
  assign sa   = ir_r[10:6];
  assign fn   = ir_r[5:0];
  assign a    = a_vld_r ? ra_q : '0;
  assign b    = b_vld_r ? rb_q : '0;
  assign c0   = c_vld_r ? rc_q : '0;
  assign imm  = {{16{ir_r[15]}}, ir_r[15:0]};
  assign zimm = {16'h0000, ir_r[15:0] & IMM_MASK};
  assign pc4  = pc_r + 32'd4;
  assign pc8  = pc_r + 32'd8;

  assign gwe = cmd.commit && res_we_r;
  assign gwd = res_val_r;

  // two copies of the gpr file give two read ports
  mieu_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_gpr_a (
    .clk(clk), .we(gwe), .waddr(res_idx_r), .wdata(gwd),
    .re(cmd.accept), .raddr(in_data.instr_word[25:21]), .rdata(ra_q)
  );
  mieu_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_gpr_b (
    .clk(clk), .we(gwe), .waddr(res_idx_r), .wdata(gwd),
    .re(cmd.accept), .raddr(in_data.instr_word[20:16]), .rdata(rb_q)
  );
  mieu_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_cop0 (
    .clk(clk), .we(cmd.commit && c0_we_r), .waddr(c0_idx_r), .wdata(c0_val_r),
    .re(cmd.accept), .raddr(in_data.instr_word[15:11]), .rdata(rc_q)
  );

  assign nm = (dsgn && a[31]) ? (32'd0 - a) : a;
  assign dm = (dsgn && b[31]) ? (32'd0 - b) : b;

  mieu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.exec && drun),
    .dividend(nm), .divisor(dm), .busy(stat.div_busy),
    .quotient(dq), .remainder(dr)
  );

  assign fq = qneg_r ? (32'd0 - dq) : dq;
  assign fr = rneg_r ? (32'd0 - dr) : dr;

  always_comb begin
    is_br = ((op == OP_SPECIAL) && (fn == FN_JR || fn == FN_JALR)) ||
            (op == OP_REGIMM) || (op >= OP_JAL && op <= OP_BGTZ);
    sup = 1'b0;
    if (op >= OP_ADDI && op <= OP_LUI) begin
      sup = 1'b1;
    end else if (op == OP_COP0) begin
      sup = (rs == C0_MF) || (rs == C0_CF) || (rs == C0_MT) || (rs == C0_CT);
    end else if (op == OP_SPECIAL) begin
      unique case (fn)
        FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
        FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
        FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
        FN_SLT, FN_SLTU: sup = 1'b1;
        default:         sup = 1'b0;
      endcase
    end
  end

  always_comb begin
    dsgn = (fn == FN_DIV) || (fn == FN_MULT);
    prod = $signed({dsgn & a[31], a}) * $signed({dsgn & b[31], b});
  end

  always_comb begin
    st     = ST_EXEC;
    tk     = 1'b0;
    npc    = pc4;
    wreq   = 1'b0;
    wi     = rd;
    wv     = '0;
    hwe    = 1'b0;
    lwe    = 1'b0;
    hv     = '0;
    lv     = '0;
    cwe    = 1'b0;
    drun   = 1'b0;
    is_div = 1'b0;
    tgt    = '0;
    ac     = a;
    if (is_br) begin
      st   = ST_BRANCH;
      wv   = pc8;
      if (op == OP_SPECIAL) begin
        wi   = (fn == FN_JALR) ? rd : 5'd0;
        tgt  = a;
      end else if (op == OP_JAL) begin
        wi   = 5'd31;
        tgt  = (pc4 & JUMP_REGION_MASK) | ((ir_r & JUMP_INDEX_MASK) << 2);
      end else begin
        wi   = (op == OP_REGIMM && rt[4]) ? 5'd31 : 5'd0;
        tgt  = pc4 + {imm[29:0], 2'b00};
      end
      wreq = 1'b1;
      // regimm with link writes r31 before sampling the condition
      if (op == OP_REGIMM && rt[4] && rs == 5'd31) begin
        ac = pc8;
      end
      priority case (op)
        OP_BEQ:    tk = (a == b);
        OP_BNE:    tk = (a != b);
        OP_BLEZ:   tk = a[31] || (a == 32'd0);
        OP_BGTZ:   tk = !a[31] && (a != 32'd0);
        OP_REGIMM: tk = rt[0] ? !ac[31] : ac[31];
        default:   tk = 1'b1;
      endcase
      npc = tk ? tgt : pc8;
    end else if (!sup) begin
      st = ST_UNSUP;
    end else if (op == OP_COP0) begin
      if (rs == C0_MT || rs == C0_CT) begin
        cwe = 1'b1;
      end else begin
        wreq = 1'b1;
        wi   = rt;
        wv   = c0;
      end
    end else if (op != OP_SPECIAL) begin
      wreq = 1'b1;
      wi   = rt;
      unique case (op)
        OP_ADDI, OP_ADDIU: wv = a + imm;
        OP_SLTI:           wv = {31'd0, $signed(a) < $signed(imm)};
        OP_SLTIU:          wv = {31'd0, a < imm};
        OP_ANDI:           wv = a & zimm;
        OP_ORI:            wv = a | zimm;
        OP_XORI:           wv = a ^ zimm;
        default:           wv = {ir_r[15:0], 16'h0000};
      endcase
    end else begin
      wreq = 1'b1;
      unique case (fn)
        FN_SLL:  wv = b << sa;
        FN_SRL:  wv = b >> sa;
        FN_SRA:  wv = 32'($signed(b) >>> sa);
        FN_SLLV: wv = b << a[4:0];
        FN_SRLV: wv = b >> a[4:0];
        FN_SRAV: wv = 32'($signed(b) >>> a[4:0]);
        FN_MFHI: wv = hi_r;
        FN_MFLO: wv = lo_r;
        FN_MTHI: begin wreq = 1'b0; hwe = 1'b1; hv = a; end
        FN_MTLO: begin wreq = 1'b0; lwe = 1'b1; lv = a; end
        FN_MULT, FN_MULTU: begin
          wreq = 1'b0; hwe = 1'b1; lwe = 1'b1;
          hv = prod[63:32]; lv = prod[31:0];
        end
        FN_DIV, FN_DIVU: begin
          wreq   = 1'b0;
          is_div = 1'b1;
          if (b == 32'd0) begin
            // zero divisor: hi keeps the dividend
            hwe = 1'b1; lwe = 1'b1; hv = a;
            lv  = (dsgn && a[31]) ? 32'd1 : ALL_ONES;
          end else begin
            drun = 1'b1;
          end
        end
        FN_ADD, FN_ADDU: wv = a + b;
        FN_SUB, FN_SUBU: wv = a - b;
        FN_AND:  wv = a & b;
        FN_OR:   wv = a | b;
        FN_XOR:  wv = a ^ b;
        FN_NOR:  wv = ~(a | b);
        FN_SLT:  wv = {31'd0, $signed(a) < $signed(b)};
        default: wv = {31'd0, a < b};
      endcase
    end
  end

  assign stat.div_run  = drun;
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ir_r    <= in_data.instr_word;
      pc_r    <= in_data.instr_pc;
      a_vld_r <= gvld_r[in_data.instr_word[25:21]];
      b_vld_r <= gvld_r[in_data.instr_word[20:16]];
      c_vld_r <= cvld_r[in_data.instr_word[15:11]];
    end
    if (cmd.exec) begin
      res_st_r   <= st;
      res_tk_r   <= tk;
      res_npc_r  <= npc;
      res_we_r   <= wreq && (wi != 5'd0);
      res_idx_r  <= (wreq && (wi != 5'd0)) ? wi : 5'd0;
      res_val_r  <= (wreq && (wi != 5'd0)) ? wv : 32'd0;
      hi_we_r    <= hwe || drun;
      lo_we_r    <= lwe || drun;
      hi_val_r   <= hv;
      lo_val_r   <= lv;
      c0_we_r    <= cwe;
      c0_idx_r   <= rd;
      c0_val_r   <= b;
      div_pend_r <= drun && is_div;
      qneg_r     <= dsgn && (a[31] != b[31]);
      rneg_r     <= dsgn && a[31];
    end
    if (cmd.commit) begin
      out_r <= '{status: res_st_r, branch_taken: res_tk_r, next_pc: res_npc_r,
                 reg_write: res_we_r, reg_index: res_idx_r, reg_value: res_val_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvld_r      <= '0;
      cvld_r      <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (res_we_r) begin
          gvld_r[res_idx_r] <= 1'b1;
        end
        if (c0_we_r) begin
          cvld_r[c0_idx_r] <= 1'b1;
        end
        if (hi_we_r) begin
          hi_r <= div_pend_r ? fr : hi_val_r;
        end
        if (lo_we_r) begin
          lo_r <= div_pend_r ? fq : lo_val_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: design/mips_integer_execute_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_top
// integer execute unit for a 32-bit r3000-style instruction stream
// ----------------------------------------------------------------------------
// usage
//   in channel: one word per instruction, raw instruction and its address,
//   valid/ready handshake
//   out channel: one result word per instruction: status, branch taken,
//   next pc and the general register write, valid/ready handshake
//   timing: accept, execute, write back; the register files are read at
//   accept, and the result word is registered at write back
//   div/divu with a nonzero divisor pass through the bit-serial divider
//   one instruction is in flight at a time, up to its write back
//   mult/multu run in the execute cycle on one 33x33 multiplier
//   reset: gprs and cop0 registers read as zero through valid bits, no
//   clearing pass; hi and lo are cleared; the output register is emptied
//   stall: a finished result waits in the output register; the next word
//   is accepted and executed, and its write back waits until out_ready
// ----------------------------------------------------------------------------
module mips_integer_execute_unit_top
  import mieu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  mieu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  // register files and execution units
  mieu_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .stat(stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // no register write means zeroed register fields
  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_write |->
      out_data.reg_index == 5'd0 && out_data.reg_value == 32'd0)
    else $error("register fields set without a write");

  // unsupported words leave no trace
  a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_UNSUP |->
      !out_data.branch_taken && !out_data.reg_write)
    else $error("unsupported word changed state");

  // taken only on branches
  a_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.branch_taken |-> out_data.status == ST_BRANCH)
    else $error("taken flag on a non-branch");

  // one instruction in flight
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

endmodule
`default_nettype wire
